/* rtl/decimal_ascii_formatter_unit_assert.svh */
// Assertion macros used by the decimal ASCII formatter emitter module.
`ifndef DECIMAL_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define DECIMAL_ASCII_FORMATTER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DAFU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("decimal formatter check failed");
`define DAFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("decimal formatter check failed");
`else
`define DAFU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define DAFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/dafu_pkg.sv */
// Package with types, codes and constants of the decimal ASCII formatter.
`timescale 1ns / 1ps
package dafu_pkg;

  localparam int DEC_DIGITS = 20;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int MAG_W      = 64;
  localparam int POS_W      = 6;
  localparam int WID_W      = 7;
  localparam int CNT_W      = 7;

  localparam logic [POS_W-1:0] TOP_POS   = POS_W'(DEC_DIGITS - 1);
  localparam logic [POS_W-1:0] CENTS_POS = POS_W'(2);

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_POINT = 7'd46;

  typedef enum logic [1:0] {
    OP_INT   = 2'd0,
    OP_PAD   = 2'd1,
    OP_MONEY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SIGN,
    EM_SKIP,
    EM_DIGIT,
    EM_POINT
  } em_state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] value;
    logic [4:0]         pad_width;
  } in_data_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_data_t;

  typedef struct packed {
    logic             money;
    logic             neg;
    logic [POS_W-1:0] minpos;
  } job_t;

  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/dafu_bcd_conv.sv */
// Bit-serial shift-and-add-3 converter from a 64-bit magnitude to 20 BCD digits.
`timescale 1ns / 1ps
module dafu_bcd_conv
  import dafu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  output logic             busy,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  assign bcd_adj = bcd_adjust(bcd_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(MAG_W);
      mag_nxt  = mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy = busy_r | done_r;
  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* rtl/dafu_emitter.sv */
// Character sequencer that shifts BCD digits out one per cycle into the output register unless stalled.
`timescale 1ns / 1ps
`include "decimal_ascii_formatter_unit_assert.svh"
module dafu_emitter
  import dafu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  job_t             job,
  input  logic [BCD_W-1:0] bcd,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output out_data_t        out_data
);

  em_state_t        state_r, state_nxt;
  logic [BCD_W-1:0] bcd_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] minpos_r;
  logic             money_r;
  logic             out_valid_r;
  out_data_t        out_data_r;

  logic       slot_free;
  logic       high_pad;
  logic [3:0] digit;
  logic       skip_ok;
  logic       load;
  logic [6:0] load_char;
  logic       load_last;
  logic       shift_bcd;
  logic       dec_pos;

  assign slot_free = !out_valid_r || !out_stall;
  assign high_pad  = pos_r > TOP_POS;
  assign digit     = high_pad ? 4'd0 : bcd_r[BCD_W-1 -: 4];
  assign skip_ok   = (pos_r > minpos_r) && (digit == 4'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EM_IDLE: begin
        if (start) begin
          state_nxt = job.neg ? EM_SIGN : EM_SKIP;
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          state_nxt = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (!skip_ok) begin
          state_nxt = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (slot_free) begin
          if (pos_r == '0) begin
            state_nxt = EM_IDLE;
          end else if (money_r && pos_r == CENTS_POS) begin
            state_nxt = EM_POINT;
          end
        end
      end
      EM_POINT: begin
        if (slot_free) begin
          state_nxt = EM_DIGIT;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    load_char = CH_ZERO;
    load_last = 1'b0;
    shift_bcd = 1'b0;
    dec_pos   = 1'b0;
    unique case (state_r)
      EM_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CH_MINUS;
        end
      end
      EM_SKIP: begin
        if (skip_ok) begin
          shift_bcd = 1'b1;
          dec_pos   = 1'b1;
        end
      end
      EM_DIGIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CH_ZERO + {3'b000, digit};
          load_last = (pos_r == '0);
          shift_bcd = !high_pad;
          dec_pos   = (pos_r != '0);
        end
      end
      EM_POINT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CH_POINT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == EM_IDLE && start) begin
      bcd_r    <= bcd;
      pos_r    <= (job.minpos > TOP_POS) ? job.minpos : TOP_POS;
      minpos_r <= job.minpos;
      money_r  <= job.money;
    end else begin
      if (shift_bcd) begin
        bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
      end
      if (dec_pos) begin
        pos_r <= pos_r - POS_W'(1);
      end
    end
    if (load) begin
      out_data_r.char_code <= load_char;
      out_data_r.last      <= load_last;
    end
  end

  assign busy      = state_r != EM_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DAFU_ASSERT_NEXT(a_last_ends_text, clk, rst_n, load && load_last, state_r == EM_IDLE)
  `DAFU_ASSERT_NOW(a_skip_above_min, clk, rst_n, state_r == EM_SKIP, pos_r >= minpos_r)
  `DAFU_ASSERT_NOW(a_point_in_money, clk, rst_n, state_r == EM_POINT,
                   money_r && pos_r == POS_W'(1))

endmodule

/* rtl/decimal_ascii_formatter_unit.sv */
// Top level: converts a 64-bit value to decimal ASCII characters, one per transaction.
// Order of work: the 64-step converter runs first, then the emitter puts out an optional minus,
// skips leading zeros (up to 19) and puts out the digits, with a point before the cents in money mode.
// A new input transaction is taken only when converter and emitter are both idle, i.e. after the
// last character of the previous one has been loaded into the output register.
// Reset (rst_n low, synchronous) clears all control state and drops out_valid.
`timescale 1ns / 1ps
module decimal_ascii_formatter_unit
  import dafu_pkg::*;
#(
  parameter int MAX_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  logic             conv_busy;
  logic             conv_done;
  logic [BCD_W-1:0] conv_bcd;
  logic             emit_busy;
  logic             accept;
  logic             conv_start;
  logic             is_neg;
  logic [MAG_W-1:0] mag;
  logic [WID_W-1:0] pad_ext;
  logic [WID_W-1:0] pad_sat;
  job_t             job_nxt;
  job_t             job_r;

  assign in_stall   = conv_busy || emit_busy;
  assign accept     = in_valid && !in_stall;
  assign conv_start = accept && (op_t'(in_data.op) != OP_NONE);

  assign is_neg  = in_data.value[MAG_W-1] && (op_t'(in_data.op) != OP_PAD);
  assign mag     = is_neg ? (MAG_W'(0) - MAG_W'(in_data.value)) : MAG_W'(in_data.value);
  assign pad_ext = {2'b00, in_data.pad_width};
  assign pad_sat = (pad_ext > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : pad_ext;

  always_comb begin
    job_nxt.money  = (op_t'(in_data.op) == OP_MONEY);
    job_nxt.neg    = is_neg;
    job_nxt.minpos = '0;
    unique case (op_t'(in_data.op))
      OP_PAD: begin
        if (pad_sat != '0) begin
          job_nxt.minpos = POS_W'(pad_sat - WID_W'(1));
        end
      end
      OP_MONEY: job_nxt.minpos = CENTS_POS;
      OP_INT, OP_NONE: job_nxt.minpos = '0;
      default: job_nxt.minpos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (conv_start) begin
      job_r <= job_nxt;
    end
  end

  dafu_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (mag),
    .busy  (conv_busy),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  dafu_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (conv_done),
    .job       (job_r),
    .bcd       (conv_bcd),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/decimal_ascii_formatter_unit_tb.sv */
// Testbench of the decimal ASCII formatter: directed table and random values checked per character.
`timescale 1ns / 1ps
module decimal_ascii_formatter_unit_tb;
  import dafu_pkg::*;

  localparam int PAD_MAX    = 24;
  localparam int RAND_ITEMS = 95;
  localparam int DRAIN      = 150;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 200000;

  typedef struct {
    in_data_t item;
    string    text;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_data_t out_data;

  out_data_t expected_chars[$];
  stim_row_t stim_rows[$];
  int        err_cnt;
  int        cycle_cnt;
  bit        quiet;
  bit        hold_req;
  int        hold_cnt;
  int        wait_cnt;

  decimal_ascii_formatter_unit #(.MAX_WIDTH(PAD_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      expected_chars.push_back('{char_code: 7'(s[k]), last: (k == s.len() - 1)});
    end
  endtask

  function automatic void format_value(input in_data_t it);
    logic [63:0] mag;
    logic [63:0] num;
    logic [6:0]  dig [20];
    logic [6:0]  txt [48];
    logic        sign;
    logic        money;
    int          nd;
    int          n;
    int          minw;
    int          frac;
    mag   = it.value[63] ? (~it.value + 64'd1) : it.value;
    num   = mag;
    sign  = 1'b0;
    money = 1'b0;
    minw  = 1;
    frac  = 0;
    case (op_t'(it.op))
      OP_INT: sign = it.value[63];
      OP_PAD: begin
        num  = it.value;
        minw = (it.pad_width > PAD_MAX) ? PAD_MAX : int'(it.pad_width);
      end
      OP_MONEY: begin
        sign  = it.value[63];
        money = 1'b1;
        num   = mag / 64'd100;
        frac  = int'(mag % 64'd100);
      end
      default: return;
    endcase
    nd = 0;
    do begin
      dig[nd] = CH_ZERO + 7'(num % 64'd10);
      num     = num / 64'd10;
      nd++;
    end while (num != 64'd0);
    n = 0;
    if (sign) begin
      txt[n] = CH_MINUS;
      n++;
    end
    for (int k = nd; k < minw; k++) begin
      txt[n] = CH_ZERO;
      n++;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      txt[n] = dig[k];
      n++;
    end
    if (money) begin
      txt[n] = CH_POINT;
      n++;
      txt[n] = CH_ZERO + 7'(frac / 10);
      n++;
      txt[n] = CH_ZERO + 7'(frac % 10);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      expected_chars.push_back('{char_code: txt[k], last: (k == n - 1)});
    end
  endfunction

  task automatic add_row(input op_t op, input logic [63:0] v, input logic [4:0] pw,
                         input string s);
    stim_row_t r;
    r.item.op        = op;
    r.item.value     = v;
    r.item.pad_width = pw;
    r.text           = s;
    stim_rows.push_back(r);
  endtask

  task automatic send_item(input in_data_t it, input string s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (s.len() > 0) begin
      push_text(s);
    end else begin
      format_value(it);
    end
  endtask

  function automatic logic [63:0] draw_value();
    logic [63:0] v;
    int          kind;
    v    = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FFF_FFFF_FFFF_FFFF;
          3: v = '1;
          4: v = 64'd1;
          default: v = 64'd99;
        endcase
      end
      1, 2, 3, 4: begin
        v = v >> $urandom_range(1, 63);
        if ($urandom_range(0, 1) == 1) begin
          v = ~v + 64'd1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("decimal_ascii_formatter_unit_tb: errors");
      $finish;
    end
  end

  // Receiver: checks each character transaction and decides the stall for the next cycle.
  initial begin
    out_stall = 1'b1;
    hold_cnt  = 0;
    wait_cnt  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected char 0x%02h last %0b",
                           out_data.char_code, out_data.last));
        end else begin
          if (out_data.char_code !== expected_chars[0].char_code ||
              out_data.last !== expected_chars[0].last) begin
            report($sformatf("char 0x%02h last %0b, expected 0x%02h last %0b",
                             out_data.char_code, out_data.last,
                             expected_chars[0].char_code, expected_chars[0].last));
          end
          void'(expected_chars.pop_front());
        end
        wait_cnt = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (!rst_n) begin
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    in_data_t it;
    int       issued;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    err_cnt   = 0;
    cycle_cnt = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;

    add_row(OP_INT,   64'd0,                   5'd0,  "0");
    add_row(OP_INT,   '1,                      5'd0,  "-1");
    add_row(OP_INT,   64'h7FFF_FFFF_FFFF_FFFF, 5'd0,  "9223372036854775807");
    add_row(OP_INT,   64'h8000_0000_0000_0000, 5'd31, "-9223372036854775808");
    add_row(OP_INT,   64'd12345,               5'd7,  "");
    add_row(OP_INT,   64'd1000000,             5'd0,  "");
    add_row(OP_PAD,   64'd0,                   5'd0,  "0");
    add_row(OP_PAD,   64'd0,                   5'd24, "000000000000000000000000");
    add_row(OP_PAD,   64'd5,                   5'd31, "000000000000000000000005");
    add_row(OP_PAD,   '1,                      5'd0,  "18446744073709551615");
    add_row(OP_PAD,   '1,                      5'd24, "000018446744073709551615");
    add_row(OP_PAD,   64'd42,                  5'd1,  "42");
    add_row(OP_PAD,   64'd7,                   5'd3,  "007");
    add_row(OP_PAD,   64'd1234,                5'd16, "");
    add_row(OP_PAD,   64'h8000_0000_0000_0000, 5'd21, "");
    add_row(OP_MONEY, 64'd0,                   5'd0,  "0.00");
    add_row(OP_MONEY, -64'sd5,                 5'd0,  "-0.05");
    add_row(OP_MONEY, 64'd100,                 5'd0,  "1.00");
    add_row(OP_MONEY, 64'h8000_0000_0000_0000, 5'd0,  "-92233720368547758.08");
    add_row(OP_MONEY, 64'h7FFF_FFFF_FFFF_FFFF, 5'd31, "92233720368547758.07");
    add_row(OP_MONEY, -64'sd12345,             5'd0,  "-123.45");
    add_row(OP_MONEY, 64'd999,                 5'd0,  "");
    add_row(OP_NONE,  64'd12345,               5'd0,  "");
    add_row(OP_NONE,  '1,                      5'd31, "");
    add_row(OP_INT,   -64'sd99,                5'd0,  "");

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_item(stim_rows[i].item, stim_rows[i].text);
    end

    issued = 0;
    while (issued < RAND_ITEMS) begin
      quiet = (issued >= 50 && issued < 75);
      if (issued == 30) begin
        hold_req = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:       it.op = OP_NONE;
        1, 2, 3: it.op = OP_INT;
        4, 5, 6: it.op = OP_PAD;
        default: it.op = OP_MONEY;
      endcase
      it.value     = draw_value();
      it.pad_width = 5'($urandom_range(0, 31));
      send_item(it, "");
      if (it.op != OP_NONE) begin
        issued++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report($sformatf("%0d characters never arrived", expected_chars.size()));
    end

    if (err_cnt == 0) begin
      $display("decimal_ascii_formatter_unit_tb: clean");
    end else begin
      $display("decimal_ascii_formatter_unit_tb: errors");
    end
    $finish;
  end

endmodule
